@@ rtl/cpsb_pkg.sv @@
package cpsb_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIP_COLUMN  = 3'd5;

	// Request kinds carried on the input tuser bit.
	localparam logic MODE_PALETTE = 1'b0;
	localparam logic MODE_PIXEL   = 1'b1;

	// Drawing modes.
	localparam logic DRAW_WHOLE = 1'b0;
	localparam logic DRAW_STRIP = 1'b1;

	// One screen write, laid out as on the output tdata (screen_x lowest).
	typedef struct packed {
		logic [15:0] pixel_color;
		logic [7:0]  screen_y;
		logic [7:0]  screen_x;
	} pix_out_t;

endpackage

@@ rtl/cpsb_ram.sv @@
module cpsb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one read port with a registered output that holds when idle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/clipped_palette_sprite_blitter_top.sv @@
// Palette sprite blitter with screen clipping and a transparent color index.
//
// Input stream (s_*): tuser selects the request kind. A palette request writes
// one 16-bit palette entry; a pixel request brings one sprite color index in
// raster order. Internal column and row counters follow the source position
// and wrap after the last pixel of the sprite. Index zero and pixels that fall
// off the screen produce nothing, but still advance the counters.
// Output stream (m_*): one screen write (x, y, color) per visible pixel.
// Configuration channel (cfg_*): always ready, write only while idle.
//
// Throughput is one request per cycle while s_tready is high. A visible pixel
// passes the registered palette read (stage 1) and then the output register
// before it appears on m_tvalid. When the receiver stalls, the output register
// and the palette read stage hold, and s_tready drops only once both are full.
// Reset clears the counters, the pipeline valids and the configuration
// registers (16x16 sprite at the origin, whole-sprite mode); the palette is not
// cleared and must be written before it is used.
module clipped_palette_sprite_blitter_top
	import cpsb_pkg::*;
#(
	parameter int SCREEN_WIDTH    = 256,
	parameter int SCREEN_HEIGHT   = 192,
	parameter int PALETTE_DEPTH   = 256,
	parameter int MAX_SPRITE_SIDE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // pal_addr[7:0], pal_color[23:8], pixel_index[31:24]
	input  logic                  s_tuser,   // mode
	// Output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // screen_x[7:0], screen_y[15:8], pixel_color[31:16]
	// Configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW  = $clog2(MAX_SPRITE_SIDE);
	localparam int XW  = ((CW > 9) ? CW : 9) + 1;
	localparam int SCM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int DW  = $clog2(SCM + 1);
	localparam int PW  = ((XW > DW) ? XW : DW) + 1;
	localparam int PAW = $clog2(PALETTE_DEPTH);

	localparam logic [XW-1:0]        SIDE_MAX = XW'(MAX_SPRITE_SIDE);
	localparam logic signed [PW-1:0] SCR_W    = PW'(SCREEN_WIDTH);
	localparam logic signed [PW-1:0] SCR_H    = PW'(SCREEN_HEIGHT);

	// Configuration registers
	logic [8:0] sprite_width_q;
	logic [8:0] sprite_height_q;
	logic [8:0] dest_x_q;
	logic [8:0] dest_y_q;
	logic       draw_mode_q;
	logic [7:0] strip_column_q;

	// Source position counters
	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;

	// Input fields
	logic [7:0]  pal_addr;
	logic [15:0] pal_color;
	logic [7:0]  pixel_index;
	logic        in_accept;
	logic        is_pixel;

	// Pipeline stage 1 (palette read in flight) and output register
	logic       valid_s1;
	logic [7:0] x_s1;
	logic [7:0] y_s1;
	logic       out_valid_q;
	pix_out_t   out_q;
	logic       out_free;
	logic       s1_adv;

	// Datapath
	logic [XW-1:0]        side_w;
	logic [XW-1:0]        side_h;
	logic                 col_wrap;
	logic                 row_wrap;
	logic signed [PW-1:0] dx_ext;
	logic signed [PW-1:0] dy_ext;
	logic signed [PW-1:0] sx;
	logic signed [PW-1:0] sy;
	logic                 col_ok;
	logic                 on_screen;
	logic                 visible;
	logic                 pal_we;
	logic [PAW-1:0]       idx_mod [256];
	logic [15:0]          ram_rdata;

	assign pal_addr    = s_tdata[7:0];
	assign pal_color   = s_tdata[23:8];
	assign pixel_index = s_tdata[31:24];

	// Handshake chain: the output register frees up when taken, stage 1 when it moves on.
	assign out_free  = !out_valid_q || m_tready;
	assign s1_adv    = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign in_accept = s_tvalid && s_tready;
	assign is_pixel  = (s_tuser == MODE_PIXEL);
	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_width_q  <= 9'd16;
			sprite_height_q <= 9'd16;
			dest_x_q        <= 9'd0;
			dest_y_q        <= 9'd0;
			draw_mode_q     <= DRAW_WHOLE;
			strip_column_q  <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data;
				CFG_SPRITE_HEIGHT: sprite_height_q <= cfg_data;
				CFG_DEST_X:        dest_x_q        <= cfg_data;
				CFG_DEST_Y:        dest_y_q        <= cfg_data;
				CFG_DRAW_MODE:     draw_mode_q     <= cfg_data[0];
				CFG_STRIP_COLUMN:  strip_column_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Effective sprite size: zero counts as one, oversize is limited.
	always_comb begin
		side_w = XW'(sprite_width_q);
		if (side_w == '0) begin
			side_w = XW'(1);
		end else if (side_w > SIDE_MAX) begin
			side_w = SIDE_MAX;
		end
		side_h = XW'(sprite_height_q);
		if (side_h == '0) begin
			side_h = XW'(1);
		end else if (side_h > SIDE_MAX) begin
			side_h = SIDE_MAX;
		end
	end

	assign col_wrap = (XW'(col_q) + XW'(1)) >= side_w;
	assign row_wrap = (XW'(row_q) + XW'(1)) >= side_h;

	// Raster counters advance on every pixel request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept && is_pixel) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Screen position and clipping.
	assign dx_ext = PW'($signed(dest_x_q));
	assign dy_ext = PW'($signed(dest_y_q));
	assign sx     = (draw_mode_q == DRAW_WHOLE) ? dx_ext + $signed(PW'(col_q)) : dx_ext;
	assign sy     = dy_ext + $signed(PW'(row_q));
	assign col_ok = (draw_mode_q == DRAW_WHOLE) || (XW'(col_q) == XW'(strip_column_q));

	assign on_screen = !sx[PW-1] && (sx < SCR_W) && !sy[PW-1] && (sy < SCR_H);
	assign visible   = is_pixel && (pixel_index != 8'd0) && col_ok && on_screen;

	// Pixel index reduced to the palette depth.
	for (genvar g = 0; g < 256; g++) begin : g_idx_mod
		assign idx_mod[g] = PAW'(g % PALETTE_DEPTH);
	end

	assign pal_we = in_accept && !is_pixel && ({1'b0, pal_addr} < 9'(PALETTE_DEPTH));

	cpsb_ram #(
		.WIDTH (16),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_addr[PAW-1:0]),
		.wdata (pal_color),
		.re    (in_accept && visible),
		.raddr (idx_mod[pixel_index]),
		.rdata (ram_rdata)
	);

	// Stage 1 holds the position while the palette read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= in_accept && visible;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && visible) begin
			x_s1 <= sx[7:0];
			y_s1 <= sy[7:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.screen_x    <= x_s1;
			out_q.screen_y    <= y_s1;
			out_q.pixel_color <= ram_rdata;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// A full stage 1 behind a stalled output must block new requests.
	a_block_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input accepted while the pipeline is full");

	// A visible pixel always lands in stage 1.
	a_visible_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && visible |=> valid_s1)
		else $error("visible pixel lost at stage 1");

	// Palette read data holds while stage 1 waits on the output.
	a_rdata_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> $stable(ram_rdata))
		else $error("palette read data changed under a stall");

	// Stage 1 moving on always produces an output.
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("stage 1 result dropped");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb
	import cpsb_pkg::*;
();

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1300;
	localparam int SCR_W        = 256;
	localparam int SCR_H        = 192;
	// Index past the last register; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	// One input request, packed as {tuser, tdata}.
	typedef struct packed {
		logic        mode;
		logic [7:0]  pixel_index;
		logic [15:0] pal_color;
		logic [7:0]  pal_addr;
	} blit_req_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BEAT} stall_kind_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata   = '0;   // pal_addr[7:0], pal_color[23:8], pixel_index[31:24]
	logic                  s_tuser   = MODE_PALETTE;   // mode
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;          // screen_x[7:0], screen_y[15:8], pixel_color[31:16]
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	clipped_palette_sprite_blitter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predicted block state and configuration.
	logic [15:0]       pal_mem [SCR_W];
	logic [7:0]        src_col    = '0;
	logic [7:0]        src_row    = '0;
	logic [8:0]        cfg_width  = 9'd16;
	logic [8:0]        cfg_height = 9'd16;
	logic signed [8:0] cfg_dest_x = '0;
	logic signed [8:0] cfg_dest_y = '0;
	logic              cfg_draw   = DRAW_WHOLE;
	logic [7:0]        cfg_strip  = '0;

	// Pending requests and expected screen writes.
	blit_req_t  req_q [$];
	pix_out_t   screen_write_q [$];

	// Palette entries written so far, seen from the request generator.
	bit         pal_known [256];
	logic [7:0] known_addr_q [$];

	blit_req_t   next_req;
	pix_out_t    got_wr;
	pix_out_t    want_wr;
	stall_kind_t stall_kind = STALL_NONE;
	int          stall_left = 0;
	int          burst_left = 0;
	int          gap_left   = 0;
	int          cycle_cnt  = 0;
	int          err_cnt    = 0;
	int          items_queued  = 0;
	int          reqs_taken    = 0;
	int          pixels_taken  = 0;
	int          writes_checked = 0;
	int          cfg_writes    = 0;
	int          setups        = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A side length of zero counts as one, anything above 256 as 256.
	function automatic int side_len(input logic [8:0] v);
		if (v == 9'd0)
			return 1;
		if (v > 9'd256)
			return 256;
		return int'(v);
	endfunction

	// Apply one accepted request: update the palette or the raster position and
	// queue the screen write the pixel causes, if any.
	function automatic void blit_predict(input blit_req_t req);
		int         w;
		int         h;
		int         sx;
		int         sy;
		logic [7:0] col;
		logic [7:0] row;
		pix_out_t   wr;

		if (req.mode == MODE_PALETTE) begin
			pal_mem[req.pal_addr] = req.pal_color;
			return;
		end
		pixels_taken++;
		w   = side_len(cfg_width);
		h   = side_len(cfg_height);
		col = src_col;
		row = src_row;

		// A counter at or past the last position wraps, even after a size change.
		if (int'(src_col) + 1 >= w) begin
			src_col = '0;
			src_row = (int'(src_row) + 1 >= h) ? 8'd0 : src_row + 8'd1;
		end else begin
			src_col = src_col + 8'd1;
		end

		if (req.pixel_index == 8'd0)
			return;
		sy = int'(cfg_dest_y) + int'(row);
		if (cfg_draw == DRAW_STRIP) begin
			if (col != cfg_strip)
				return;
			sx = int'(cfg_dest_x);
		end else begin
			sx = int'(cfg_dest_x) + int'(col);
		end
		if (sx < 0 || sx >= SCR_W || sy < 0 || sy >= SCR_H)
			return;
		wr.screen_x    = sx[7:0];
		wr.screen_y    = sy[7:0];
		wr.pixel_color = pal_mem[req.pixel_index];
		screen_write_q.push_back(wr);
	endfunction

	function automatic void queue_palette(input logic [7:0] addr, input logic [15:0] color);
		blit_req_t r;

		r.mode        = MODE_PALETTE;
		r.pal_addr    = addr;
		r.pal_color   = color;
		r.pixel_index = 8'($urandom);
		req_q.push_back(r);
		if (!pal_known[addr]) begin
			pal_known[addr] = 1'b1;
			known_addr_q.push_back(addr);
		end
		items_queued++;
	endfunction

	function automatic void queue_pixel(input logic [7:0] idx);
		blit_req_t r;

		r.mode        = MODE_PIXEL;
		r.pixel_index = idx;
		r.pal_addr    = 8'($urandom);
		r.pal_color   = 16'($urandom);
		req_q.push_back(r);
		items_queued++;
	endfunction

	// Transparent index now and then, otherwise an entry that holds a color.
	function automatic logic [7:0] pick_index();
		if (known_addr_q.size() == 0 || $urandom_range(0, 3) == 0)
			return 8'd0;
		return known_addr_q[$urandom_range(0, known_addr_q.size() - 1)];
	endfunction

	function automatic logic [8:0] pick_side();
		int r;

		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 9'd0;
				1: return 9'd1;
				2: return 9'd256;
				default: return 9'd511;
			endcase
		end
		if (r == 1)
			return 9'($urandom_range(0, 511));
		return 9'($urandom_range(1, 24));
	endfunction

	function automatic logic [8:0] pick_offset(input int span);
		int r;

		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 9'h100;
				1: return 9'h0FF;
				2: return 9'h1FF;
				default: return 9'h000;
			endcase
		end
		if (r == 1)
			return 9'($urandom_range(0, 511));
		return 9'($urandom_range(0, span)) - 9'd8;
	endfunction

	// One register write over the configuration channel.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SPRITE_WIDTH:  cfg_width  = val;
			CFG_SPRITE_HEIGHT: cfg_height = val;
			CFG_DEST_X:        cfg_dest_x = val;
			CFG_DEST_Y:        cfg_dest_y = val;
			CFG_DRAW_MODE:     cfg_draw   = val[0];
			CFG_STRIP_COLUMN:  cfg_strip  = val[7:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// Hold the sender until every expected write is out, then let the pipe drain.
	task automatic settle();
		do
			@(negedge clk);
		while (req_q.size() != 0 || s_tvalid || screen_write_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A new random setup; width goes first so the strip column can follow it.
	task automatic pick_setup();
		bit any;

		any = 1'b0;
		if ($urandom_range(0, 1) == 1) begin
			cfg_write(CFG_SPRITE_WIDTH, pick_side());
			any = 1'b1;
		end
		if ($urandom_range(0, 1) == 1) begin
			cfg_write(CFG_SPRITE_HEIGHT, pick_side());
			any = 1'b1;
		end
		if ($urandom_range(0, 1) == 1) begin
			cfg_write(CFG_DEST_X, pick_offset(248));
			any = 1'b1;
		end
		if ($urandom_range(0, 1) == 1) begin
			cfg_write(CFG_DEST_Y, pick_offset(186));
			any = 1'b1;
		end
		if ($urandom_range(0, 1) == 1) begin
			cfg_write(CFG_STRIP_COLUMN, ($urandom_range(0, 7) == 0) ?
				9'($urandom_range(0, 255)) : 9'($urandom_range(0, side_len(cfg_width) - 1)));
			any = 1'b1;
		end
		if (!any || $urandom_range(0, 2) == 0)
			cfg_write(CFG_DRAW_MODE, ($urandom_range(0, 3) == 0) ? 9'(DRAW_STRIP) : 9'(DRAW_WHOLE));
		if ($urandom_range(0, 19) == 0)
			cfg_write(CFG_SPARE, 9'($urandom));
		setups++;
	endtask

	// A run of sprite pixels with a few palette updates mixed in.
	task automatic queue_sprite_run();
		int n;

		n = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) : $urandom_range(8, 80);
		repeat ($urandom_range(0, 3))
			queue_palette(8'($urandom), 16'($urandom));
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				queue_palette(8'($urandom), 16'($urandom));
			else
				queue_pixel(pick_index());
		end
	endtask

	// Request driver: bursts of random length with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= MODE_PALETTE;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				blit_predict(blit_req_t'({s_tuser, s_tdata}));
				reqs_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_q.size() != 0) begin
					next_req = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= next_req.mode;
					s_tdata  <= {next_req.pixel_index, next_req.pal_color, next_req.pal_addr};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each screen write and stalls on a pattern of its own.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_kind = STALL_NONE;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_wr = m_tdata;
				if (screen_write_q.size() == 0) begin
					$error("unexpected screen write x=%0d y=%0d color=%h",
						got_wr.screen_x, got_wr.screen_y, got_wr.pixel_color);
					err_cnt++;
				end else begin
					want_wr = screen_write_q.pop_front();
					writes_checked++;
					if (got_wr.screen_x !== want_wr.screen_x) begin
						$error("screen_x: expected %0d, got %0d", want_wr.screen_x, got_wr.screen_x);
						err_cnt++;
					end
					if (got_wr.screen_y !== want_wr.screen_y) begin
						$error("screen_y: expected %0d, got %0d", want_wr.screen_y, got_wr.screen_y);
						err_cnt++;
					end
					if (got_wr.pixel_color !== want_wr.pixel_color) begin
						$error("pixel_color: expected %h, got %h",
							want_wr.pixel_color, got_wr.pixel_color);
						err_cnt++;
					end
				end
			end
			if (stall_left == 0) begin
				stall_kind = stall_kind_t'($urandom_range(0, 3));
				stall_left = $urandom_range(8, 120);
			end else begin
				stall_left--;
			end
			case (stall_kind)
				STALL_NONE:  m_tready <= 1'b1;
				STALL_COIN:  m_tready <= ($urandom_range(0, 1) == 1);
				STALL_HEAVY: m_tready <= ($urandom_range(0, 4) == 0);
				default:     m_tready <= (stall_left[1:0] == 2'b00);
			endcase
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int rand_goal;

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Reset setup: extreme palette addresses and colors, transparent index.
		@(negedge clk);
		queue_palette(8'd255, 16'hFFFF);
		queue_palette(8'd1, 16'h0000);
		queue_palette(8'd128, 16'hA5A5);
		queue_palette(8'd0, 16'h5A5A);
		queue_pixel(8'd255);
		queue_pixel(8'd0);
		queue_pixel(8'd1);
		queue_pixel(8'd128);

		// Zero width and oversize height while mid-row, origin at the far corner.
		settle();
		cfg_write(CFG_SPRITE_WIDTH, 9'd0);
		cfg_write(CFG_SPRITE_HEIGHT, 9'd511);
		cfg_write(CFG_DEST_X, 9'd255);
		cfg_write(CFG_DEST_Y, 9'd190);
		cfg_write(CFG_SPARE, 9'h1FF);
		setups++;
		@(negedge clk);
		queue_pixel(8'd255);
		queue_pixel(8'd1);
		queue_pixel(8'd255);

		// Oversize width, one row, origin one column left of the screen.
		settle();
		cfg_write(CFG_SPRITE_WIDTH, 9'd511);
		cfg_write(CFG_SPRITE_HEIGHT, 9'd1);
		cfg_write(CFG_DEST_X, 9'h1FF);
		cfg_write(CFG_DEST_Y, 9'd0);
		setups++;
		@(negedge clk);
		queue_pixel(8'd128);
		queue_pixel(8'd255);
		queue_pixel(8'd1);

		// Strip mode: a column past the sprite draws nothing, then a real column.
		settle();
		cfg_write(CFG_SPRITE_WIDTH, 9'd4);
		cfg_write(CFG_SPRITE_HEIGHT, 9'd4);
		cfg_write(CFG_DEST_X, 9'd10);
		cfg_write(CFG_DEST_Y, 9'd5);
		cfg_write(CFG_DRAW_MODE, 9'(DRAW_STRIP));
		cfg_write(CFG_STRIP_COLUMN, 9'd200);
		setups++;
		@(negedge clk);
		repeat (4) queue_pixel(8'd255);
		settle();
		cfg_write(CFG_STRIP_COLUMN, 9'd2);
		setups++;
		@(negedge clk);
		queue_pixel(8'd1);
		queue_pixel(8'd128);
		queue_pixel(8'd255);
		queue_pixel(8'd1);

		// Random setups, each followed by a run of sprite traffic.
		rand_goal = items_queued + RANDOM_ITEMS;
		while (items_queued < rand_goal) begin
			settle();
			pick_setup();
			@(negedge clk);
			queue_sprite_run();
		end
		settle();

		$display("tb: %0d requests taken (%0d pixels) over %0d setups and %0d register writes",
			reqs_taken, pixels_taken, setups, cfg_writes);
		$display("tb: %0d screen writes checked, %0d mismatches", writes_checked, err_cnt);
		if (err_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cpsb_pkg.sv
rtl/cpsb_ram.sv
rtl/clipped_palette_sprite_blitter_top.sv
test/tb.sv
